### src/qslerp_pkg.sv
// Shared types and constants for the quaternion slerp pipeline.
// Holds the input and output word structs, the carried payload and the arctangent table.
// No dependencies.
package qslerp_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam logic [30:0] THRESH_RESET = 31'd10737;

    localparam int CW = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS = 31;

    localparam logic [30:0] W_ONE = 31'h4000_0000;
    localparam logic signed [CW-1:0] W_S = 34'sh0_4000_0000;
    localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;

    localparam logic signed [CW-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
        34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
        34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
        34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
        34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
        34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002
    };

    typedef struct packed {
        logic signed [31:0] from_x;
        logic signed [31:0] from_y;
        logic signed [31:0] from_z;
        logic signed [31:0] from_w;
        logic signed [31:0] to_x;
        logic signed [31:0] to_y;
        logic signed [31:0] to_z;
        logic signed [31:0] to_w;
        logic [30:0]        blend;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
    } t_out_word;

    typedef struct packed {
        logic [3:0][31:0] from;
        logic [3:0][32:0] to;
        logic [30:0]      t30;
        logic             slerp;
    } t_carry;

endpackage

### src/quaternion_slerp.sv
// Quaternion slerp top level: a fully pipelined datapath with one word per cycle unless the output stalls.
// Dot product, square root, CORDIC angle, two CORDIC sines, two dividers, weighted sum.
// Depends on qslerp_pkg.
//
//   channel  | valid    | stall    | word
//   ---------+----------+----------+-------------
//   input    | i_valid  | o_stall  | i_in_word
//   output   | o_valid  | i_stall  | o_out_word
//   config   | i_cfg_we | -        | i_cfg_data
//
// A word enters every cycle while the output is not stalled, and its result passes
// through 136 register stages set by the 31-step square root, the 30-step angle CORDIC,
// the 30-step sine CORDICs and the 31-step dividers, each one step per stage.
// All stages advance together; a stalled output freezes the whole pipeline.
// The synchronous reset clears the valid bits and loads the threshold register.
module quaternion_slerp #(
    parameter int FRAC_BITS = qslerp_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  qslerp_pkg::t_in_word  i_in_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output qslerp_pkg::t_out_word o_out_word,
    input  logic                  i_cfg_we,
    input  logic [30:0]           i_cfg_data
);

    localparam int UP = 30 - FRAC_BITS;
    localparam int NC = qslerp_pkg::CORDIC_STEPS;
    localparam int NS = qslerp_pkg::SQRT_STEPS;
    localparam int ND = qslerp_pkg::DIV_STEPS;
    localparam int CW = qslerp_pkg::CW;
    localparam logic signed [31:0] ONE_S = 32'sd1 <<< FRAC_BITS;
    localparam logic [30:0] ONE_U = 31'd1 << FRAC_BITS;
    localparam logic signed [65:0] SUM_ONE = 66'sd1 <<< FRAC_BITS;
    localparam logic [63:0] SQ_TOP = 64'd1 << 60;
    localparam logic signed [65:0] RND = 66'sd536870912;

    logic en;
    logic [30:0] r_thr;

    // Front stages
    logic r1_vld, r2_vld, r3_vld, r4_vld;
    logic n1_vld;
    qslerp_pkg::t_carry n1_car, r1_car, n2_car, r2_car, n3_car, r3_car, n4_car, r4_car;
    logic signed [63:0] n1_prod [0:3];
    logic signed [63:0] r1_prod [0:3];
    logic signed [65:0] n2_sum, r2_sum;
    logic [30:0] n3_c, r3_c;
    logic [30:0] n4_c30, r4_c30;
    logic [61:0] n4_sq, r4_sq;

    // Square root
    logic [NS:0] r_sr_vld, n_sr_vld;
    qslerp_pkg::t_carry r_sr_car [0:NS];
    qslerp_pkg::t_carry n_sr_car [0:NS];
    logic [30:0] r_sr_c30 [0:NS];
    logic [30:0] n_sr_c30 [0:NS];
    logic [63:0] r_sr_rem [0:NS];
    logic [63:0] n_sr_rem [0:NS];
    logic [30:0] r_sr_root [0:NS];
    logic [30:0] n_sr_root [0:NS];

    // Angle CORDIC
    logic [NC:0] r_vx_vld, n_vx_vld;
    qslerp_pkg::t_carry r_vx_car [0:NC];
    qslerp_pkg::t_carry n_vx_car [0:NC];
    logic [30:0] r_vx_s [0:NC];
    logic [30:0] n_vx_s [0:NC];
    logic signed [CW-1:0] r_vx_x [0:NC];
    logic signed [CW-1:0] n_vx_x [0:NC];
    logic signed [CW-1:0] r_vx_y [0:NC];
    logic signed [CW-1:0] n_vx_y [0:NC];
    logic signed [CW-1:0] r_vx_z [0:NC];
    logic signed [CW-1:0] n_vx_z [0:NC];

    // Partial angles
    logic r_p_vld;
    qslerp_pkg::t_carry r_p_car;
    logic [30:0] r_p_s;
    logic signed [65:0] r_p_pf, r_p_pt, n_p_pf, n_p_pt;

    // Sine CORDICs, lane 0 for the start weight and lane 1 for the target weight
    logic [NC:0] r_ro_vld, n_ro_vld;
    qslerp_pkg::t_carry r_ro_car [0:NC];
    qslerp_pkg::t_carry n_ro_car [0:NC];
    logic [30:0] r_ro_s [0:NC];
    logic [30:0] n_ro_s [0:NC];
    logic signed [CW-1:0] r_ro_x [0:NC][0:1];
    logic signed [CW-1:0] n_ro_x [0:NC][0:1];
    logic signed [CW-1:0] r_ro_y [0:NC][0:1];
    logic signed [CW-1:0] n_ro_y [0:NC][0:1];
    logic signed [CW-1:0] r_ro_z [0:NC][0:1];
    logic signed [CW-1:0] n_ro_z [0:NC][0:1];

    // Clamped sines
    logic r_sn_vld;
    qslerp_pkg::t_carry r_sn_car;
    logic [30:0] r_sn_s;
    logic [30:0] r_sn_v [0:1];
    logic [30:0] n_sn_v [0:1];

    // Dividers
    logic [ND:0] r_dv_vld, n_dv_vld;
    qslerp_pkg::t_carry r_dv_car [0:ND];
    qslerp_pkg::t_carry n_dv_car [0:ND];
    logic [30:0] r_dv_s [0:ND];
    logic [30:0] n_dv_s [0:ND];
    logic [63:0] r_dv_rem [0:ND][0:1];
    logic [63:0] n_dv_rem [0:ND][0:1];
    logic [30:0] r_dv_q [0:ND][0:1];
    logic [30:0] n_dv_q [0:ND][0:1];
    logic r_dv_ovf [0:ND][0:1];
    logic n_dv_ovf [0:ND][0:1];

    // Weights, products, sums, output
    logic r_w_vld, r_m_vld, r_a_vld, r_out_vld;
    qslerp_pkg::t_carry r_w_car;
    logic [30:0] r_w_wf, r_w_wt, n_w_wf, n_w_wt;
    logic signed [65:0] r_m_f [0:3];
    logic signed [65:0] r_m_t [0:3];
    logic signed [65:0] n_m_f [0:3];
    logic signed [65:0] n_m_t [0:3];
    logic signed [65:0] r_a_acc [0:3];
    logic signed [65:0] n_a_acc [0:3];
    logic signed [31:0] r_out [0:3];
    logic signed [31:0] n_out [0:3];

    assign en = !(r_out_vld && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_vld;
    assign o_out_word.out_x = r_out[0];
    assign o_out_word.out_y = r_out[1];
    assign o_out_word.out_z = r_out[2];
    assign o_out_word.out_w = r_out[3];

    always_comb begin
        logic signed [31:0] fr [0:3];
        logic signed [31:0] tq [0:3];
        logic [30:0] t;
        fr[0] = i_in_word.from_x;
        fr[1] = i_in_word.from_y;
        fr[2] = i_in_word.from_z;
        fr[3] = i_in_word.from_w;
        tq[0] = i_in_word.to_x;
        tq[1] = i_in_word.to_y;
        tq[2] = i_in_word.to_z;
        tq[3] = i_in_word.to_w;
        t = (i_in_word.blend > ONE_U) ? ONE_U : i_in_word.blend;
        n1_vld = i_valid;
        n1_car.t30 = t << UP;
        n1_car.slerp = 1'b0;
        for (int k = 0; k < 4; k++) begin
            n1_prod[k] = 64'(fr[k]) * 64'(tq[k]);
            n1_car.from[k] = fr[k];
            n1_car.to[k] = 33'(tq[k]);
        end
    end

    always_comb begin
        n2_car = r1_car;
        n2_sum = '0;
        for (int k = 0; k < 4; k++) begin
            n2_sum = n2_sum + 66'(r1_prod[k] >>> FRAC_BITS);
        end
    end

    always_comb begin
        logic signed [31:0] cl;
        logic neg;
        neg = r2_sum[65];
        if (r2_sum > SUM_ONE) begin
            cl = ONE_S;
        end else if (r2_sum < -SUM_ONE) begin
            cl = -ONE_S;
        end else begin
            cl = 32'(r2_sum);
        end
        n3_c = neg ? 31'(-cl) : 31'(cl);
        n3_car = r2_car;
        for (int k = 0; k < 4; k++) begin
            n3_car.to[k] = neg ? -$signed(r2_car.to[k]) : r2_car.to[k];
        end
    end

    always_comb begin
        n4_c30 = r3_c << UP;
        n4_sq = 62'(n4_c30) * 62'(n4_c30);
        n4_car = r3_car;
        n4_car.slerp = (32'(ONE_U) - 32'(r3_c)) > 32'(r_thr);
    end

    always_comb begin
        logic [63:0] trial;
        n_sr_vld[0] = r4_vld;
        n_sr_car[0] = r4_car;
        n_sr_c30[0] = r4_c30;
        n_sr_rem[0] = SQ_TOP - 64'(r4_sq);
        n_sr_root[0] = '0;
        for (int k = 1; k <= NS; k++) begin
            trial = (64'(r_sr_root[k-1]) << (NS - k + 1)) + (64'd1 << (2 * (NS - k)));
            n_sr_vld[k] = r_sr_vld[k-1];
            n_sr_car[k] = r_sr_car[k-1];
            n_sr_c30[k] = r_sr_c30[k-1];
            if (r_sr_rem[k-1] >= trial) begin
                n_sr_rem[k] = r_sr_rem[k-1] - trial;
                n_sr_root[k] = r_sr_root[k-1] | (31'd1 << (NS - k));
            end else begin
                n_sr_rem[k] = r_sr_rem[k-1];
                n_sr_root[k] = r_sr_root[k-1];
            end
        end
    end

    always_comb begin
        n_vx_vld[0] = r_sr_vld[NS];
        n_vx_car[0] = r_sr_car[NS];
        n_vx_s[0] = r_sr_root[NS];
        n_vx_x[0] = CW'(r_sr_c30[NS]);
        n_vx_y[0] = CW'(r_sr_root[NS]);
        n_vx_z[0] = '0;
        for (int j = 1; j <= NC; j++) begin
            n_vx_vld[j] = r_vx_vld[j-1];
            n_vx_car[j] = r_vx_car[j-1];
            n_vx_s[j] = r_vx_s[j-1];
            if (!r_vx_y[j-1][CW-1]) begin
                n_vx_x[j] = r_vx_x[j-1] + (r_vx_y[j-1] >>> (j - 1));
                n_vx_y[j] = r_vx_y[j-1] - (r_vx_x[j-1] >>> (j - 1));
                n_vx_z[j] = r_vx_z[j-1] + qslerp_pkg::ATAN_TAB[j-1];
            end else begin
                n_vx_x[j] = r_vx_x[j-1] - (r_vx_y[j-1] >>> (j - 1));
                n_vx_y[j] = r_vx_y[j-1] + (r_vx_x[j-1] >>> (j - 1));
                n_vx_z[j] = r_vx_z[j-1] - qslerp_pkg::ATAN_TAB[j-1];
            end
        end
    end

    always_comb begin
        logic [30:0] wf_lin;
        wf_lin = qslerp_pkg::W_ONE - r_vx_car[NC].t30;
        n_p_pf = $signed(66'(wf_lin)) * 66'(r_vx_z[NC]);
        n_p_pt = $signed(66'(r_vx_car[NC].t30)) * 66'(r_vx_z[NC]);
    end

    always_comb begin
        n_ro_vld[0] = r_p_vld;
        n_ro_car[0] = r_p_car;
        n_ro_s[0] = r_p_s;
        n_ro_z[0][0] = CW'(r_p_pf >>> 30);
        n_ro_z[0][1] = CW'(r_p_pt >>> 30);
        for (int l = 0; l < 2; l++) begin
            n_ro_x[0][l] = qslerp_pkg::GAIN_INV;
            n_ro_y[0][l] = '0;
        end
        for (int j = 1; j <= NC; j++) begin
            n_ro_vld[j] = r_ro_vld[j-1];
            n_ro_car[j] = r_ro_car[j-1];
            n_ro_s[j] = r_ro_s[j-1];
            for (int l = 0; l < 2; l++) begin
                if (!r_ro_z[j-1][l][CW-1]) begin
                    n_ro_x[j][l] = r_ro_x[j-1][l] - (r_ro_y[j-1][l] >>> (j - 1));
                    n_ro_y[j][l] = r_ro_y[j-1][l] + (r_ro_x[j-1][l] >>> (j - 1));
                    n_ro_z[j][l] = r_ro_z[j-1][l] - qslerp_pkg::ATAN_TAB[j-1];
                end else begin
                    n_ro_x[j][l] = r_ro_x[j-1][l] + (r_ro_y[j-1][l] >>> (j - 1));
                    n_ro_y[j][l] = r_ro_y[j-1][l] - (r_ro_x[j-1][l] >>> (j - 1));
                    n_ro_z[j][l] = r_ro_z[j-1][l] + qslerp_pkg::ATAN_TAB[j-1];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_ro_y[NC][l][CW-1]) begin
                n_sn_v[l] = '0;
            end else if (r_ro_y[NC][l] > qslerp_pkg::W_S) begin
                n_sn_v[l] = qslerp_pkg::W_ONE;
            end else begin
                n_sn_v[l] = 31'(r_ro_y[NC][l]);
            end
        end
    end

    always_comb begin
        logic [63:0] ds;
        n_dv_vld[0] = r_sn_vld;
        n_dv_car[0] = r_sn_car;
        n_dv_s[0] = r_sn_s;
        for (int l = 0; l < 2; l++) begin
            n_dv_rem[0][l] = 64'(r_sn_v[l]) << 30;
            n_dv_q[0][l] = '0;
            n_dv_ovf[0][l] = 32'(r_sn_v[l]) >= {r_sn_s, 1'b0};
        end
        for (int k = 1; k <= ND; k++) begin
            ds = 64'(r_dv_s[k-1]) << (ND - k);
            n_dv_vld[k] = r_dv_vld[k-1];
            n_dv_car[k] = r_dv_car[k-1];
            n_dv_s[k] = r_dv_s[k-1];
            for (int l = 0; l < 2; l++) begin
                n_dv_ovf[k][l] = r_dv_ovf[k-1][l];
                if (r_dv_rem[k-1][l] >= ds) begin
                    n_dv_rem[k][l] = r_dv_rem[k-1][l] - ds;
                    n_dv_q[k][l] = r_dv_q[k-1][l] | (31'd1 << (ND - k));
                end else begin
                    n_dv_rem[k][l] = r_dv_rem[k-1][l];
                    n_dv_q[k][l] = r_dv_q[k-1][l];
                end
            end
        end
    end

    always_comb begin
        logic use_sl;
        logic [30:0] wq [0:1];
        use_sl = r_dv_car[ND].slerp && (r_dv_s[ND] != '0);
        for (int l = 0; l < 2; l++) begin
            if (r_dv_ovf[ND][l] || (r_dv_q[ND][l] > qslerp_pkg::W_ONE)) begin
                wq[l] = qslerp_pkg::W_ONE;
            end else begin
                wq[l] = r_dv_q[ND][l];
            end
        end
        n_w_wf = use_sl ? wq[0] : (qslerp_pkg::W_ONE - r_dv_car[ND].t30);
        n_w_wt = use_sl ? wq[1] : r_dv_car[ND].t30;
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_m_f[k] = $signed(66'(r_w_wf)) * 66'($signed(r_w_car.from[k]));
            n_m_t[k] = $signed(66'(r_w_wt)) * 66'($signed(r_w_car.to[k]));
            n_a_acc[k] = r_m_f[k] + r_m_t[k] + RND;
        end
    end

    always_comb begin
        logic signed [65:0] v;
        for (int k = 0; k < 4; k++) begin
            v = r_a_acc[k] >>> 30;
            if (v > SUM_ONE) begin
                n_out[k] = ONE_S;
            end else if (v < -SUM_ONE) begin
                n_out[k] = -ONE_S;
            end else begin
                n_out[k] = 32'(v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qslerp_pkg::THRESH_RESET;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r_sr_vld <= '0;
            r_vx_vld <= '0;
            r_p_vld <= 1'b0;
            r_ro_vld <= '0;
            r_sn_vld <= 1'b0;
            r_dv_vld <= '0;
            r_w_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_a_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (en) begin
                r1_vld <= n1_vld;
                r2_vld <= r1_vld;
                r3_vld <= r2_vld;
                r4_vld <= r3_vld;
                r_sr_vld <= n_sr_vld;
                r_vx_vld <= n_vx_vld;
                r_p_vld <= r_vx_vld[NC];
                r_ro_vld <= n_ro_vld;
                r_sn_vld <= r_ro_vld[NC];
                r_dv_vld <= n_dv_vld;
                r_w_vld <= r_dv_vld[ND];
                r_m_vld <= r_w_vld;
                r_a_vld <= r_m_vld;
                r_out_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_car <= n1_car;
            r1_prod <= n1_prod;
            r2_car <= n2_car;
            r2_sum <= n2_sum;
            r3_car <= n3_car;
            r3_c <= n3_c;
            r4_car <= n4_car;
            r4_c30 <= n4_c30;
            r4_sq <= n4_sq;
            r_sr_car <= n_sr_car;
            r_sr_c30 <= n_sr_c30;
            r_sr_rem <= n_sr_rem;
            r_sr_root <= n_sr_root;
            r_vx_car <= n_vx_car;
            r_vx_s <= n_vx_s;
            r_vx_x <= n_vx_x;
            r_vx_y <= n_vx_y;
            r_vx_z <= n_vx_z;
            r_p_car <= r_vx_car[NC];
            r_p_s <= r_vx_s[NC];
            r_p_pf <= n_p_pf;
            r_p_pt <= n_p_pt;
            r_ro_car <= n_ro_car;
            r_ro_s <= n_ro_s;
            r_ro_x <= n_ro_x;
            r_ro_y <= n_ro_y;
            r_ro_z <= n_ro_z;
            r_sn_car <= r_ro_car[NC];
            r_sn_s <= r_ro_s[NC];
            r_sn_v <= n_sn_v;
            r_dv_car <= n_dv_car;
            r_dv_s <= n_dv_s;
            r_dv_rem <= n_dv_rem;
            r_dv_q <= n_dv_q;
            r_dv_ovf <= n_dv_ovf;
            r_w_car <= r_dv_car[ND];
            r_w_wf <= n_w_wf;
            r_w_wt <= n_w_wt;
            r_m_f <= n_m_f;
            r_m_t <= n_m_t;
            r_a_acc <= n_a_acc;
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_word.out_x <= ONE_S) && (o_out_word.out_x >= -ONE_S)
                 && (o_out_word.out_w <= ONE_S) && (o_out_word.out_w >= -ONE_S))
        else $error("output component beyond unit range");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w_vld |-> (r_w_wf <= qslerp_pkg::W_ONE) && (r_w_wt <= qslerp_pkg::W_ONE))
        else $error("blend weight above one");

    a_linear_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_w_vld && !r_w_car.slerp) |-> (32'(r_w_wf) + 32'(r_w_wt) == 32'(qslerp_pkg::W_ONE)))
        else $error("linear weights do not sum to one");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sr_vld[NS] |-> (r_sr_rem[NS] <= {32'd0, r_sr_root[NS], 1'b0}))
        else $error("square root remainder too large");
`endif

endmodule
